>>> rtl/core/jdconv_pkg.sv
// Shared types, constants and tables for the Julian day converter.
package jdconv_pkg;

  localparam int STAGES = 5;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int JDN_W   = 23;

  localparam int TDATA_W = 56;

  localparam logic [JDN_W-1:0] JDN_MIN        = 23'd1721424;
  localparam logic [JDN_W-1:0] JDN_MAX        = 23'd5373484;
  localparam logic [JDN_W-1:0] GREG_FIRST_JDN = 23'd2299161;

  localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd9999;
  localparam logic [YEAR_W-1:0] CUTOVER_YEAR = 14'd1582;
  localparam logic [MONTH_W-1:0] CUTOVER_MON = 4'd10;
  localparam logic [DAY_W-1:0] CUTOVER_DAY   = 5'd15;

  localparam logic [23:0] DAYS_PER_4Y    = 24'd1461;
  localparam logic [23:0] JDN_DATE_BASE  = 24'd1720995;
  localparam logic [24:0] N1_OFFSET      = 25'd7468865;
  localparam logic [22:0] B_TO_C         = 23'd1524;
  localparam logic [29:0] N2_SCALE       = 30'd100;
  localparam logic [29:0] N2_OFFSET      = 30'd12210;
  localparam logic [13:0] YEAR_OFS_LATE  = 14'd4716;
  localparam logic [13:0] YEAR_OFS_EARLY = 14'd4715;

  // Floor division by constants as multiply by rounded-up reciprocal.
  localparam int       CENT_SHIFT = 21;
  localparam longint   CENT_DIV   = 100;
  localparam logic [27:0] CENT_MUL =
    28'(((64'd1 << CENT_SHIFT) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  localparam int       A_SHIFT = 42;
  localparam longint   A_DIV   = 146097;
  localparam logic [48:0] A_MUL =
    49'(((64'd1 << A_SHIFT) + 64'(A_DIV) - 64'd1) / 64'(A_DIV));

  localparam int       DD_SHIFT = 46;
  localparam longint   DD_DIV   = 36525;
  localparam logic [59:0] DD_MUL =
    60'(((64'd1 << DD_SHIFT) + 64'(DD_DIV) - 64'd1) / 64'(DD_DIV));

  typedef struct packed {
    logic               op;
    logic               err;
    logic [HOUR_W-1:0]  hour;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   dom;
    logic               greg;
    logic [JDN_W-1:0]   jdn;
    logic [23:0]        p1461;
    logic [6:0]         cent;
    logic [6:0]         a;
    logic [22:0]        c;
    logic [29:0]        n2;
    logic [13:0]        dd;
    logic [9:0]         x;
  } pipe_item_t;

  typedef struct packed {
    logic               err;
    logic [JDN_W-1:0]   jdn;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } out_item_t;

  // floor(30.6001 * v)
  function automatic logic [8:0] month_days(input logic [3:0] v);
    logic [8:0] r;
    unique case (v)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/julian_day_date_converter_unit.sv
// Pipelined converter between civil dates and Julian day numbers.
//
// Channel  Dir  Handshake          Payload
// in_      in   tvalid / tready    tuser: operation; tdata: date, hour, day number
// out_     out  tvalid / tready    tuser: range_error; tdata: date, hour, day number
//
// One transaction per cycle while the output is not stalled.
// The path is set by the reciprocal multiplies for the century and year quotients.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled output holds its stage; upstream stages still advance into empty slots.
module julian_day_date_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // year[13:0] month[17:14] day_of_month[22:18]
                                  // hour[27:23] day_number[50:28] zero[55:51]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_year[13:0] out_month[17:14] out_day[22:18]
                                  // out_hour[27:23] out_day_number[50:28] zero[55:51]
  output logic [0:0]  out_tuser   // range_error[0]
);

  localparam int NS = jdconv_pkg::STAGES;

  jdconv_pkg::pipe_item_t st_r   [NS];
  jdconv_pkg::pipe_item_t st_nxt [NS];
  logic [NS-1:0]          vld_r;
  logic [NS-1:0]          adv;
  logic                   adv_out;
  jdconv_pkg::out_item_t  out_r;
  jdconv_pkg::out_item_t  out_nxt;
  logic                   out_vld_r;

  logic        in_op;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_dom;
  logic [4:0]  in_hour;
  logic [22:0] in_jdn;
  logic        jan_feb;
  logic [13:0] yadj;
  logic [3:0]  madj;
  logic        greg_date;
  logic        greg_num;
  logic        err_date;
  logic        err_num;
  logic [27:0] cent_prod;
  logic [24:0] n1;
  logic [48:0] a_prod;

  logic [3:0]  madj1;
  logic [23:0] jdn_date;
  logic [22:0] b_val;

  logic [59:0] dd_prod;

  logic [24:0] e_prod;
  logic [22:0] x_full;

  logic [3:0]  g;
  logic [9:0]  day_full;
  logic [3:0]  mo;
  logic [13:0] ynum;

  // Stall chain
  always_comb begin
    adv_out     = !out_vld_r || out_tready;
    adv[NS-1]   = !vld_r[NS-1] || adv_out;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  // Stage 0: decode, range checks, first reciprocal products
  assign in_op    = in_tuser[0];
  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_dom   = in_tdata[22:18];
  assign in_hour  = in_tdata[27:23];
  assign in_jdn   = in_tdata[50:28];

  assign jan_feb = in_month < 4'd3;
  assign yadj    = jan_feb ? in_year - 14'd1 : in_year;
  assign madj    = jan_feb ? in_month + 4'd12 : in_month;

  assign greg_date = (yadj > jdconv_pkg::CUTOVER_YEAR) ||
                     (yadj == jdconv_pkg::CUTOVER_YEAR && madj > jdconv_pkg::CUTOVER_MON) ||
                     (yadj == jdconv_pkg::CUTOVER_YEAR && madj == jdconv_pkg::CUTOVER_MON &&
                      in_dom >= jdconv_pkg::CUTOVER_DAY);
  assign greg_num  = in_jdn >= jdconv_pkg::GREG_FIRST_JDN;

  assign err_date = (in_year == 14'd0) || (in_year > jdconv_pkg::YEAR_MAX) ||
                    (in_month == 4'd0) || (in_month > 4'd12) || (in_dom == 5'd0);
  assign err_num  = (in_jdn < jdconv_pkg::JDN_MIN) || (in_jdn > jdconv_pkg::JDN_MAX);

  assign cent_prod = 28'(yadj) * jdconv_pkg::CENT_MUL;
  assign n1        = {in_jdn, 2'b00} - jdconv_pkg::N1_OFFSET;
  assign a_prod    = 49'(n1[23:0]) * jdconv_pkg::A_MUL;

  always_comb begin
    st_nxt[0]       = '0;
    st_nxt[0].op    = in_op;
    st_nxt[0].err   = in_op ? err_num : err_date;
    st_nxt[0].hour  = in_hour;
    st_nxt[0].year  = in_year;
    st_nxt[0].month = in_month;
    st_nxt[0].dom   = in_dom;
    st_nxt[0].greg  = in_op ? greg_num : greg_date;
    st_nxt[0].jdn   = in_jdn;
    st_nxt[0].p1461 = 24'(yadj) * jdconv_pkg::DAYS_PER_4Y;
    st_nxt[0].cent  = cent_prod[jdconv_pkg::CENT_SHIFT +: 7];
    st_nxt[0].a     = a_prod[jdconv_pkg::A_SHIFT +: 7];
  end

  // Stage 1: day number from date; shifted day number for the inverse
  assign madj1 = (st_r[0].month < 4'd3) ? st_r[0].month + 4'd12 : st_r[0].month;

  always_comb begin
    jdn_date = 24'(st_r[0].p1461[23:2]) + 24'(jdconv_pkg::month_days(madj1 + 4'd1)) +
               24'(st_r[0].dom) + jdconv_pkg::JDN_DATE_BASE;
    if (st_r[0].greg) begin
      jdn_date = jdn_date + 24'd2 + 24'(st_r[0].cent[6:2]) - 24'(st_r[0].cent);
    end
    b_val = st_r[0].greg ?
            st_r[0].jdn + 23'd1 + 23'(st_r[0].a) - 23'(st_r[0].a[6:2]) : st_r[0].jdn;
    st_nxt[1]     = st_r[0];
    st_nxt[1].jdn = st_r[0].op ? st_r[0].jdn : jdn_date[22:0];
    st_nxt[1].c   = b_val + jdconv_pkg::B_TO_C;
  end

  // Stage 2: scaled numerator for the year quotient
  always_comb begin
    st_nxt[2]    = st_r[1];
    st_nxt[2].n2 = 30'(st_r[1].c) * jdconv_pkg::N2_SCALE - jdconv_pkg::N2_OFFSET;
  end

  // Stage 3: year quotient
  assign dd_prod = 60'(st_r[2].n2) * jdconv_pkg::DD_MUL;

  always_comb begin
    st_nxt[3]    = st_r[2];
    st_nxt[3].dd = dd_prod[jdconv_pkg::DD_SHIFT +: 14];
  end

  // Stage 4: day within the shifted year
  assign e_prod = 25'(st_r[3].dd) * 25'(jdconv_pkg::DAYS_PER_4Y);
  assign x_full = st_r[3].c - e_prod[24:2];

  always_comb begin
    st_nxt[4]   = st_r[3];
    st_nxt[4].x = x_full[9:0];
  end

  // Output stage: month, day and year from the day within the year, or the input date
  always_comb begin
    g = 4'd0;
    for (int v = 1; v < 16; v++) begin
      if (st_r[4].x > 10'(jdconv_pkg::month_days(4'(v)))) begin
        g = 4'(v);
      end
    end
  end

  assign day_full = st_r[4].x - 10'(jdconv_pkg::month_days(g));
  assign mo       = (g <= 4'd13) ? g - 4'd1 : g - 4'd13;
  assign ynum     = (mo > 4'd2) ? st_r[4].dd - jdconv_pkg::YEAR_OFS_LATE :
                                  st_r[4].dd - jdconv_pkg::YEAR_OFS_EARLY;

  always_comb begin
    out_nxt     = '0;
    out_nxt.err = st_r[4].err;
    if (!st_r[4].err) begin
      out_nxt.hour = st_r[4].hour;
      out_nxt.jdn  = st_r[4].jdn;
      if (st_r[4].op) begin
        out_nxt.year  = ynum;
        out_nxt.month = mo;
        out_nxt.day   = day_full[4:0];
      end else begin
        out_nxt.year  = st_r[4].year;
        out_nxt.month = st_r[4].month;
        out_nxt.day   = st_r[4].dom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv_out) begin
        out_vld_r <= vld_r[NS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (adv_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {5'd0, out_r.jdn, out_r.hour, out_r.day, out_r.month, out_r.year};
  assign out_tuser[0] = out_r.err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("range error result carries nonzero fields");

  a_ok_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[17:14] >= 4'd1 && out_tdata[17:14] <= 4'd12 && out_tdata[13:0] != 14'd0)
    else $error("valid result with month or year out of range");

  a_ok_jdn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[50:28] >= jdconv_pkg::JDN_MIN && out_tdata[50:28] <= jdconv_pkg::JDN_MAX)
    else $error("valid result with day number out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && (&vld_r))
    else $error("input stalled while pipeline has a free slot");

endmodule
